// File: hw/rtl/mnc_pkg.sv
// mnc_pkg: constants, types and control program of the note compressor
`default_nettype none

package mnc_pkg;

    localparam int HELD_BYTES = 16;
    localparam int NOTE_W     = 7;
    localparam int HELD_W     = HELD_BYTES * 8;
    localparam int BYTE_IDX_W = $clog2(HELD_BYTES);
    localparam int DIV_W      = 16;
    localparam int DVS_W      = 8;
    localparam int CNT_W      = 5;
    localparam int PC_W       = 4;
    localparam int RES_CNT_W  = 7;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 5;

    localparam logic [RES_CNT_W-1:0] MAX_RESULTS  = 7'd64;
    localparam logic [RES_CNT_W-1:0] LAST_RESULT  = 7'd63;

    // high nibbles and full status codes
    localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
    localparam logic [7:0] ST_BEND      = 8'hE0;
    localparam logic [7:0] ST_NOTE_ON   = 8'h90;
    localparam logic [7:0] ST_NOTE_OFF  = 8'h80;

    localparam logic [13:0] BEND_CENTER  = 14'd8192;
    localparam logic [6:0]  OFFSET_RESET = 7'd64;
    localparam logic [3:0]  KPS_RESET    = 4'd6;
    localparam logic [3:0]  KPS_MIN      = 4'd2;
    localparam logic [3:0]  KPS_MAX      = 4'd8;
    localparam logic [4:0]  BR_RESET     = 5'd2;
    localparam logic [4:0]  BR_MIN       = 5'd1;
    localparam logic [4:0]  BR_MAX       = 5'd24;

    localparam logic [CFG_IDX_W-1:0] CFG_KEYS_PER_STEP = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEND_RANGE    = 8'd1;

    localparam logic [CNT_W-1:0] KEY_DIV_STEPS  = 5'd7;
    localparam logic [CNT_W-1:0] BEND_DIV_STEPS = 5'd16;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_KDIV_LOAD,
        OP_DIV_STEP,
        OP_NOTE,
        OP_BDIV_LOAD,
        OP_EMIT_BEND,
        OP_EMIT_ON,
        OP_EMIT_OFF,
        OP_TURN,
        OP_SCAN
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_IF_TURN,
        C_DIV,
        C_IF_OTHER,
        C_IF_OFF,
        C_SCAN
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
    localparam logic [PC_W-1:0] PC_OFF  = 4'd10;
    localparam logic [PC_W-1:0] PC_TURN = 4'd11;

    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        unique case (pc)
            4'd0:    w = '{op: OP_ACCEPT,    cond: C_NEXT,     target: PC_IDLE};
            4'd1:    w = '{op: OP_NOP,       cond: C_IF_TURN,  target: PC_TURN};
            4'd2:    w = '{op: OP_KDIV_LOAD, cond: C_NEXT,     target: PC_IDLE};
            4'd3:    w = '{op: OP_DIV_STEP,  cond: C_DIV,      target: PC_IDLE};
            4'd4:    w = '{op: OP_NOTE,      cond: C_IF_OTHER, target: PC_IDLE};
            4'd5:    w = '{op: OP_NOP,       cond: C_IF_OFF,   target: PC_OFF};
            4'd6:    w = '{op: OP_BDIV_LOAD, cond: C_NEXT,     target: PC_IDLE};
            4'd7:    w = '{op: OP_DIV_STEP,  cond: C_DIV,      target: PC_IDLE};
            4'd8:    w = '{op: OP_EMIT_BEND, cond: C_NEXT,     target: PC_IDLE};
            4'd9:    w = '{op: OP_EMIT_ON,   cond: C_JUMP,     target: PC_IDLE};
            4'd10:   w = '{op: OP_EMIT_OFF,  cond: C_JUMP,     target: PC_IDLE};
            4'd11:   w = '{op: OP_TURN,      cond: C_NEXT,     target: PC_IDLE};
            4'd12:   w = '{op: OP_SCAN,      cond: C_SCAN,     target: PC_IDLE};
            default: w = '{op: OP_NOP,       cond: C_JUMP,     target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/midi_note_compressor_with_bend.sv
// midi_note_compressor_with_bend: microcoded note folder with pitch-bend correction
// one item at a time; a control program in a table steps a shared restoring divider
// note-on: a bend result, then the note-on as the last result, then the next item is taken
// note-off: one result; other messages give no result before the next item is taken
// encoder turn: a note-off for each held note, up to 64; a stalled output holds the program
// aresetn resets settings to defaults, note offset to 64, the held set, program and output valid
`default_nettype none

module midi_note_compressor_with_bend (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    // status_byte[7:0], first_data[14:8], second_data[21:15], turn_direction[23:22]
    input  wire  [mnc_pkg::IN_DATA_W-1:0]        s_tdata,
    // command[0]
    input  wire                                  s_tuser,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    // out_status[7:0], out_first[14:8], out_second[21:15], zero[23:22]
    output logic [mnc_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                 m_tlast,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [mnc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [mnc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import mnc_pkg::*;

    logic [3:0]            kps_reg, kps_next;
    logic [4:0]            br_reg, br_next;
    logic [NOTE_W-1:0]     offset_reg, offset_next;
    logic [HELD_W-1:0]     held_reg, held_next;
    logic [PC_W-1:0]       pc_reg, pc_next;
    logic                  turn_reg, turn_next;
    logic [3:0]            st_reg, st_next;
    logic [6:0]            key_reg, key_next;
    logic [6:0]            vel_reg, vel_next;
    logic [1:0]            dir_reg, dir_next;
    logic [DIV_W-1:0]      q_reg, q_next;
    logic [DVS_W-1:0]      rem_reg, rem_next;
    logic [DVS_W-1:0]      dvs_reg, dvs_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [NOTE_W-1:0]     note_reg, note_next;
    logic                  neg_reg, neg_next;
    logic [2:0]            mag_reg, mag_next;
    logic [DVS_W-1:0]      prod_reg, prod_next;
    logic [BYTE_IDX_W-1:0] byte_reg, byte_next;
    logic [RES_CNT_W-1:0]  res_cnt_reg, res_cnt_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [21:0]           m_data_reg, m_data_next;
    logic                  m_tlast_reg, m_tlast_next;

    uword_t                uw;
    logic [3:0]            s_sat;
    logic [4:0]            r_sat;
    logic                  is_on, is_off;
    logic                  can_emit, stall, emitting;
    logic [DVS_W:0]        dtrial, dsub;
    logic                  dfits;
    logic [2:0]            rem3, half3;
    logic [8:0]            prod_w;
    logic [13:0]           bend_w;
    logic [7:0]            cur_byte;
    logic [2:0]            lo;
    logic                  emit_scan;
    logic [HELD_W-1:0]     held_clr;
    logic                  rest_empty;

    assign uw        = ucode(pc_reg);
    assign s_tready  = (uw.op == OP_ACCEPT);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {2'b00, m_data_reg};
    assign m_tlast   = m_tlast_reg;

    always_comb begin
        s_sat = kps_reg;
        if (kps_reg < KPS_MIN) s_sat = KPS_MIN;
        if (kps_reg > KPS_MAX) s_sat = KPS_MAX;
        r_sat = br_reg;
        if (br_reg < BR_MIN) r_sat = BR_MIN;
        if (br_reg > BR_MAX) r_sat = BR_MAX;
    end

    assign is_off = (st_reg == NIB_NOTE_OFF) || (st_reg == NIB_NOTE_ON && vel_reg == 7'd0);
    assign is_on  = (st_reg == NIB_NOTE_ON) && (vel_reg != 7'd0);

    // one restoring divider step: shift in the next dividend bit, subtract if it fits
    assign dtrial = {rem_reg, q_reg[DIV_W-1]};
    assign dfits  = (dtrial >= {1'b0, dvs_reg});
    assign dsub   = dtrial - {1'b0, dvs_reg};

    assign rem3   = rem_reg[2:0];
    assign half3  = s_sat[3:1];
    assign prod_w = {5'd0, s_sat} * {4'd0, r_sat};
    assign bend_w = neg_reg ? (BEND_CENTER - q_reg[13:0]) : (BEND_CENTER + q_reg[13:0]);

    // held-set scan: lowest set bit of the current byte
    assign cur_byte = held_reg[{byte_reg, 3'b000} +: 8];
    always_comb begin
        lo = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (cur_byte[i]) lo = 3'(i);
        end
    end
    assign emit_scan  = (|cur_byte) && (res_cnt_reg != MAX_RESULTS);
    assign held_clr   = held_reg & ~(HELD_W'(1) << {byte_reg, lo});
    assign rest_empty = (held_clr == '0);

    assign can_emit = !m_tvalid_reg || m_tready;
    assign emitting = (uw.op == OP_EMIT_BEND) || (uw.op == OP_EMIT_ON) ||
                      (uw.op == OP_EMIT_OFF) || (uw.op == OP_SCAN && emit_scan);
    assign stall    = (emitting && !can_emit) || (uw.op == OP_ACCEPT && !s_tvalid);

    always_comb begin
        kps_next      = kps_reg;
        br_next       = br_reg;
        offset_next   = offset_reg;
        held_next     = held_reg;
        pc_next       = pc_reg;
        turn_next     = turn_reg;
        st_next       = st_reg;
        key_next      = key_reg;
        vel_next      = vel_reg;
        dir_next      = dir_reg;
        q_next        = q_reg;
        rem_next      = rem_reg;
        dvs_next      = dvs_reg;
        cnt_next      = cnt_reg;
        note_next     = note_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        prod_next     = prod_reg;
        byte_next     = byte_reg;
        res_cnt_next  = res_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_tlast_next  = m_tlast_reg;

        if (cfg_valid) begin
            if (cfg_index == CFG_KEYS_PER_STEP) kps_next = cfg_data[3:0];
            if (cfg_index == CFG_BEND_RANGE)    br_next  = cfg_data;
        end

        if (!stall) begin
            unique case (uw.op)
                OP_NOP: begin
                end
                OP_ACCEPT: begin
                    turn_next = s_tuser;
                    st_next   = s_tdata[7:4];
                    key_next  = s_tdata[14:8];
                    vel_next  = s_tdata[21:15];
                    dir_next  = s_tdata[23:22];
                end
                OP_KDIV_LOAD: begin
                    // key in the top bits so seven steps leave key / s in the low bits
                    q_next   = {key_reg, 9'd0};
                    rem_next = '0;
                    dvs_next = {4'd0, s_sat};
                    cnt_next = KEY_DIV_STEPS;
                end
                OP_DIV_STEP: begin
                    q_next   = {q_reg[DIV_W-2:0], dfits};
                    rem_next = dfits ? dsub[DVS_W-1:0] : dtrial[DVS_W-1:0];
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                OP_NOTE: begin
                    note_next = q_reg[6:0] + offset_reg;
                    neg_next  = (rem3 < half3);
                    mag_next  = (rem3 < half3) ? (half3 - rem3) : (rem3 - half3);
                    prod_next = prod_w[DVS_W-1:0];
                end
                OP_BDIV_LOAD: begin
                    q_next   = {mag_reg, 13'd0};
                    rem_next = '0;
                    dvs_next = prod_reg;
                    cnt_next = BEND_DIV_STEPS;
                end
                OP_EMIT_BEND: begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = {bend_w[13:7], bend_w[6:0], ST_BEND};
                    m_tlast_next  = 1'b0;
                end
                OP_EMIT_ON: begin
                    m_tvalid_next       = 1'b1;
                    m_data_next         = {vel_reg, note_reg, ST_NOTE_ON};
                    m_tlast_next        = 1'b1;
                    held_next[note_reg] = 1'b1;
                end
                OP_EMIT_OFF: begin
                    m_tvalid_next       = 1'b1;
                    m_data_next         = {vel_reg, note_reg, st_reg, 4'h0};
                    m_tlast_next        = 1'b1;
                    held_next[note_reg] = 1'b0;
                end
                OP_TURN: begin
                    offset_next  = offset_reg + {{5{dir_reg[1]}}, dir_reg};
                    byte_next    = '0;
                    res_cnt_next = '0;
                end
                OP_SCAN: begin
                    if (emit_scan) begin
                        m_tvalid_next = 1'b1;
                        m_data_next   = {7'd0, byte_reg, lo, ST_NOTE_OFF};
                        m_tlast_next  = rest_empty || (res_cnt_reg == LAST_RESULT);
                        held_next     = held_clr;
                        res_cnt_next  = res_cnt_reg + RES_CNT_W'(1);
                    end else begin
                        // byte done (or result cap reached): drop what is left, move on
                        held_next[{byte_reg, 3'b000} +: 8] = 8'd0;
                        byte_next = byte_reg + BYTE_IDX_W'(1);
                    end
                end
                default: begin
                end
            endcase

            unique case (uw.cond)
                C_NEXT:     pc_next = pc_reg + PC_W'(1);
                C_JUMP:     pc_next = uw.target;
                C_IF_TURN:  pc_next = turn_reg ? uw.target : pc_reg + PC_W'(1);
                C_DIV:      pc_next = (cnt_reg == CNT_W'(1)) ? pc_reg + PC_W'(1) : pc_reg;
                C_IF_OTHER: pc_next = (!is_on && !is_off) ? uw.target : pc_reg + PC_W'(1);
                C_IF_OFF:   pc_next = is_off ? uw.target : pc_reg + PC_W'(1);
                C_SCAN: begin
                    pc_next = (!emit_scan && byte_reg == BYTE_IDX_W'(HELD_BYTES - 1))
                              ? uw.target : pc_reg;
                end
                default:    pc_next = PC_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kps_reg      <= KPS_RESET;
            br_reg       <= BR_RESET;
            offset_reg   <= OFFSET_RESET;
            held_reg     <= '0;
            pc_reg       <= PC_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            kps_reg      <= kps_next;
            br_reg       <= br_next;
            offset_reg   <= offset_next;
            held_reg     <= held_next;
            pc_reg       <= pc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        turn_reg    <= turn_next;
        st_reg      <= st_next;
        key_reg     <= key_next;
        vel_reg     <= vel_next;
        dir_reg     <= dir_next;
        q_reg       <= q_next;
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        cnt_reg     <= cnt_next;
        note_reg    <= note_next;
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        prod_reg    <= prod_next;
        byte_reg    <= byte_next;
        res_cnt_reg <= res_cnt_next;
        m_data_reg  <= m_data_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/mnc_checker.sv
// mnc_checker: port-level assertions for the note compressor, bound to the top level
`default_nettype none

module mnc_checker (
    input wire                              aclk,
    input wire                              aresetn,
    input wire                              s_tvalid,
    input wire                              s_tready,
    input wire                              m_tvalid,
    input wire                              m_tready,
    input wire [mnc_pkg::OUT_DATA_W-1:0]    m_tdata,
    input wire                              m_tlast
);
    import mnc_pkg::*;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result item changed while stalled");

    // one item at a time: no second item right after one is taken
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken in back-to-back cycles");

    // a bend item is never marked last: its note-on follows
    a_bend_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[7:0] == ST_BEND) |-> !m_tlast)
        else $error("bend item marked last");

    // when ready for a new item only the final result may still wait
    a_ready_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && m_tvalid |-> m_tlast)
        else $error("new item accepted with results still pending");

endmodule

bind midi_note_compressor_with_bend mnc_checker u_mnc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// File: verif/tb_midi_note_compressor_with_bend.sv
// testbench for the midi note compressor: directed and random messages and turns, checked in order
module tb_midi_note_compressor_with_bend;
    timeunit 1ns;
    timeprecision 1ps;

    import mnc_pkg::*;

    localparam logic CMD_MSG  = 1'b0;
    localparam logic CMD_TURN = 1'b1;

    localparam logic [1:0] DIR_HOLD  = 2'b00;
    localparam logic [1:0] DIR_UP    = 2'b01;
    localparam logic [1:0] DIR_BACK2 = 2'b10;
    localparam logic [1:0] DIR_DOWN  = 2'b11;

    localparam logic [7:0] ST_POLY_AT = 8'hA5;
    localparam logic [7:0] ST_CTRL    = 8'hB0;
    localparam logic [7:0] ST_SYSEX   = 8'hF0;
    localparam logic [7:0] ST_RESET   = 8'hFF;
    localparam logic [7:0] ST_ZERO    = 8'h00;
    localparam logic [7:0] ST_DATA    = 8'h7F;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd2;

    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_SHOWN    = 10;

    typedef struct packed {
        logic [7:0] status;
        logic [6:0] first;
        logic [6:0] second;
        logic       last;
    } midi_msg_t;

    class note_fold_scoreboard;
        logic [3:0]   keys_per_step;
        logic [4:0]   bend_range;
        logic [6:0]   offset;
        logic [127:0] held;
        midi_msg_t    pending_msgs[$];
        int           mismatches;

        function new();
            keys_per_step = KPS_RESET;
            bend_range    = BR_RESET;
            offset        = OFFSET_RESET;
            held          = '0;
            mismatches    = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_KEYS_PER_STEP) begin
                keys_per_step = value[3:0];
            end else if (idx == CFG_BEND_RANGE) begin
                bend_range = value;
            end
        endfunction

        function void queue_msg(logic [7:0] st, logic [6:0] a, logic [6:0] b);
            pending_msgs.push_back('{status: st, first: a, second: b, last: 1'b0});
        endfunction

        // folds one accepted item into the expected output messages
        function void note_input(logic cmd, logic [IN_DATA_W-1:0] data);
            logic [7:0]  st;
            logic [6:0]  key;
            logic [6:0]  vel;
            logic [6:0]  note;
            logic [1:0]  dir;
            logic [13:0] bend;
            int          s;
            int          r;
            int          diff;
            int          corr;
            int          n;
            n   = 0;
            st  = {data[7:4], 4'h0};
            key = data[14:8];
            vel = data[21:15];
            dir = data[23:22];
            if (cmd == CMD_TURN) begin
                offset = offset + {{5{dir[1]}}, dir};
                for (int i = 0; i < 128; i++) begin
                    if (held[i] && n < MAX_RESULTS) begin
                        queue_msg(ST_NOTE_OFF, 7'(i), 7'd0);
                        n++;
                    end
                end
                held = '0;
            end else begin
                s = keys_per_step;
                r = bend_range;
                if (s < KPS_MIN) s = KPS_MIN;
                if (s > KPS_MAX) s = KPS_MAX;
                if (r < BR_MIN) r = BR_MIN;
                if (r > BR_MAX) r = BR_MAX;
                note = 7'(int'(key) / s + int'(offset));
                if (st == ST_NOTE_OFF || (st == ST_NOTE_ON && vel == 7'd0)) begin
                    queue_msg(st, note, vel);
                    n = 1;
                    held[note] = 1'b0;
                end else if (st == ST_NOTE_ON) begin
                    // bend places the folded note between semitones, truncated toward zero
                    diff = int'(key) % s - s / 2;
                    corr = (diff * 8192) / (s * r);
                    bend = 14'(int'(BEND_CENTER) + corr);
                    queue_msg(ST_BEND, bend[6:0], bend[13:7]);
                    queue_msg(ST_NOTE_ON, note, vel);
                    n = 2;
                    held[note] = 1'b1;
                end
            end
            if (n > 0) pending_msgs[pending_msgs.size() - 1].last = 1'b1;
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic last);
            midi_msg_t want;
            bit        bad;
            bad  = 1'b0;
            want = '0;
            if (pending_msgs.size() == 0) begin
                bad = 1'b1;
            end else begin
                want = pending_msgs.pop_front();
                bad  = data[7:0] !== want.status || data[14:8] !== want.first ||
                       data[21:15] !== want.second || data[23:22] !== 2'b00 ||
                       last !== want.last;
            end
            if (bad) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("%0t: result st=%h a=%0d b=%0d pad=%b last=%b, wanted st=%h a=%0d b=%0d last=%b%s",
                             $realtime, data[7:0], data[14:8], data[21:15], data[23:22], last,
                             want.status, want.first, want.second, want.last,
                             pending_msgs.size() == 0 && want == '0 ? " (none queued)" : "");
                end
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    bit steady = 1'b0;
    note_fold_scoreboard sb = new;

    midi_note_compressor_with_bend uut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(5_000_000);
        $display("end of test: mismatches");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
            m_tready <= steady || ($urandom_range(99) >= 35);
        end
    end

    // tvalid is only lowered while idling, so back-to-back items keep it high
    task automatic send_item(input logic cmd, input logic [IN_DATA_W-1:0] data);
        if (!steady) begin
            while ($urandom_range(99) < 35) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(cmd, data);
    endtask

    task automatic send_msg(input logic [7:0] st, input logic [6:0] a, input logic [6:0] b);
        send_item(CMD_MSG, {2'($urandom), b, a, st});
    endtask

    task automatic send_turn(input logic [1:0] dir);
        send_item(CMD_TURN, {dir, 22'($urandom)});
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending_msgs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_register(idx, value);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] kps, input logic [CFG_DATA_W-1:0] br);
        write_reg(CFG_KEYS_PER_STEP, kps);
        write_reg(CFG_BEND_RANGE, br);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        int pick;
        int nib;
        pick = $urandom_range(99);
        if (pick < 50) begin
            send_msg(ST_NOTE_ON | 8'($urandom_range(15)), 7'($urandom), 7'($urandom_range(127, 1)));
        end else if (pick < 65) begin
            send_msg(ST_NOTE_OFF | 8'($urandom_range(15)), 7'($urandom), 7'($urandom));
        end else if (pick < 72) begin
            send_msg(ST_NOTE_ON | 8'($urandom_range(15)), 7'($urandom), 7'd0);
        end else if (pick < 82) begin
            nib = $urandom_range(13);
            if (nib >= 8) nib += 2;
            send_msg({4'(nib), 4'($urandom)}, 7'($urandom), 7'($urandom));
        end else if (pick < 92) begin
            send_turn(2'($urandom));
        end else begin
            send_item(1'($urandom), 24'($urandom));
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] kps_set [6];
        logic [CFG_DATA_W-1:0] br_set  [6];
        kps_set = '{5'd2, 5'd8, 5'd0, 5'd31, 5'd3, 5'd5};
        br_set  = '{5'd1, 5'd24, 5'd0, 5'd31, 5'd12, 5'd7};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: six keys per step, two semitones of bend
        send_msg(ST_NOTE_ON, 7'd0, 7'd127);
        send_msg(ST_NOTE_ON | 8'h0F, 7'd127, 7'd1);
        send_msg(ST_NOTE_ON | 8'h05, 7'd3, 7'd64);
        send_msg(ST_NOTE_ON | 8'h0A, 7'd5, 7'd100);
        send_msg(ST_NOTE_OFF | 8'h0F, 7'd127, 7'd127);
        send_msg(ST_NOTE_ON | 8'h03, 7'd0, 7'd0);
        send_msg(ST_SYSEX, 7'd127, 7'd127);
        send_msg(ST_POLY_AT, 7'd10, 7'd20);
        send_msg(ST_ZERO, 7'd0, 7'd0);
        send_msg(ST_RESET, 7'd127, 7'd0);
        send_msg(ST_DATA, 7'd64, 7'd64);
        send_msg(ST_CTRL, 7'd1, 7'd2);
        send_turn(DIR_UP);
        send_turn(DIR_HOLD);
        send_msg(ST_NOTE_ON, 7'd60, 7'd90);
        send_msg(ST_NOTE_ON, 7'd66, 7'd90);
        send_turn(DIR_HOLD);
        send_msg(ST_NOTE_ON, 7'd126, 7'd127);
        send_turn(DIR_DOWN);
        send_msg(ST_NOTE_ON, 7'd11, 7'd33);
        send_turn(DIR_BACK2);
        send_msg(ST_NOTE_OFF, 7'd40, 7'd0);
        send_item(CMD_TURN, 24'hFFFFFF);
        wait_drained();
        write_reg(CFG_UNUSED, 5'd31);
        cfg_valid <= 1'b0;

        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            if (ph == 5) set_config(5'($urandom_range(KPS_MAX, KPS_MIN)),
                                    5'($urandom_range(BR_MAX, BR_MIN)));
            else set_config(kps_set[ph], br_set[ph]);
            steady <= (ph == 2);
            if (ph == 0) begin
                // every foldable note held at once, then one flush of 64 note-offs
                for (int k = 0; k < 128; k += 2) send_msg(ST_NOTE_ON, 7'(k), 7'($urandom_range(127, 1)));
                send_turn(2'($urandom));
            end
            for (int i = 0; i < 60; i++) random_item();
        end

        wait_drained();
        if (sb.mismatches == 0 && sb.pending_msgs.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/mnc_pkg.sv
hw/rtl/midi_note_compressor_with_bend.sv
hw/rtl/mnc_checker.sv
verif/tb_midi_note_compressor_with_bend.sv
